// ----- hdl/acc_pkg.sv -----
// Shared types and constants of the alignment consistency checker.
// Used by the checker, the compare unit and the stream interfaces; depends on nothing.
`timescale 1ns / 1ps

package acc_pkg;

  // Field widths and the default sentence length.
  localparam int unsigned POS_W         = 8;
  localparam int unsigned MODE_W        = 2;
  localparam int unsigned VERD_W        = 2;
  localparam int unsigned AccMaxWords   = 256;

  typedef logic [POS_W-1:0] pos_t;

  // Item commands.
  typedef enum logic [MODE_W-1:0] {
    MODE_CLEAR = 2'd0,
    MODE_LINK  = 2'd1,
    MODE_QUERY = 2'd2
  } mode_e;

  // Result codes.
  typedef enum logic [VERD_W-1:0] {
    VERD_ACK  = 2'd0,
    VERD_OK   = 2'd1,
    VERD_BAD  = 2'd2,
    VERD_EXCL = 2'd3
  } verdict_e;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LINK_RD,
    ST_LINK_SRC,
    ST_LINK_TGT,
    ST_SRC_WALK,
    ST_TGT_WALK,
    ST_DONE,
    ST_WIPE
  } state_e;

  // Request to the shared min/max compare unit.
  typedef struct packed {
    logic init;
    pos_t acc_lo;
    pos_t acc_hi;
    pos_t cand_lo;
    pos_t cand_hi;
  } mm_req_t;

  // Answer of the shared min/max compare unit.
  typedef struct packed {
    pos_t lo;
    pos_t hi;
    logic outside;
  } mm_rsp_t;

endpackage

// ----- hdl/acc_if.sv -----
// Valid/ready stream interfaces for input and result words of the checker.
// Depends on acc_pkg for field widths.
`timescale 1ns / 1ps

interface acc_in_if;
  logic                        valid;
  logic                        ready;
  logic [acc_pkg::MODE_W-1:0]  mode;
  logic [acc_pkg::POS_W-1:0]   link_source;
  logic [acc_pkg::POS_W-1:0]   link_target;
  logic [acc_pkg::POS_W-1:0]   span_first;
  logic [acc_pkg::POS_W-1:0]   span_last;

  modport source (output valid, mode, link_source, link_target, span_first, span_last,
                  input ready);
  modport sink   (input valid, mode, link_source, link_target, span_first, span_last,
                  output ready);
endinterface

interface acc_out_if;
  logic                        valid;
  logic                        ready;
  logic [acc_pkg::VERD_W-1:0]  verdict;
  logic                        has_links;
  logic [acc_pkg::POS_W-1:0]   projected_low;
  logic [acc_pkg::POS_W-1:0]   projected_high;

  modport source (output valid, verdict, has_links, projected_low, projected_high,
                  input ready);
  modport sink   (input valid, verdict, has_links, projected_low, projected_high,
                  output ready);
endinterface

// ----- hdl/acc_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module acc_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // Registered read port, holds data while idle
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ----- hdl/acc_minmax_unit.sv -----
// Shared compare unit: widens a min/max pair or checks a pair against bounds.
// Depends on acc_pkg for the request and answer structs.
`timescale 1ns / 1ps

module acc_minmax_unit (
  input  acc_pkg::mm_req_t req_i,
  output acc_pkg::mm_rsp_t rsp_o
);

  logic below_lo;
  logic above_hi;

  // Compare candidate against the accumulated bounds
  assign below_lo = req_i.cand_lo < req_i.acc_lo;
  assign above_hi = req_i.cand_hi > req_i.acc_hi;

  // Take the candidate on init, otherwise widen
  assign rsp_o.lo      = (req_i.init || below_lo) ? req_i.cand_lo : req_i.acc_lo;
  assign rsp_o.hi      = (req_i.init || above_hi) ? req_i.cand_hi : req_i.acc_hi;
  assign rsp_o.outside = below_lo || above_hi;

endmodule

// ----- hdl/alignment_consistency_checker.sv -----
// Alignment consistency checker. Keeps the lowest/highest partner of each source
// and target position in two RAMs, each entry tagged with a linked bit and a
// 3-bit epoch; an entry counts as linked only when its bit is set and its epoch
// matches the current one. One shared min/max compare unit serves link updates,
// the source walk and the target check. One word is taken at a time. A clear or
// unused command, and a link outside the sentence length, goes straight to its
// result; an added link reads both entries, then writes the source entry, then
// the target entry. A query of span first..last reads each source position of the
// span and then checks each target position of its projection lo..hi, the single
// read port of each RAM visiting one position a cycle; the target walk stops at the
// first inconsistent word. A query whose span holds no linked word skips the target
// walk, a reversed span reads no position and a one-word span goes straight to its
// result. The done state of an item is held while an earlier result word still
// waits. After reset the block is not ready while a clearing pass marks every entry
// unlinked. A clear advances the epoch; every eighth clear wraps it and repeats the
// pass. Depends on acc_pkg, acc_if, acc_ram and acc_minmax_unit.
`timescale 1ns / 1ps

module alignment_consistency_checker #(
  parameter int unsigned MAX_WORDS = acc_pkg::AccMaxWords
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  acc_in_if.sink    in_i,
  acc_out_if.source out_o
);

  localparam int unsigned PosSpan = 1 << acc_pkg::POS_W;
  localparam int unsigned Depth   = (MAX_WORDS < PosSpan) ? MAX_WORDS : PosSpan;
  localparam int unsigned AddrW   = $clog2(Depth);
  localparam int unsigned CntW    = acc_pkg::POS_W + 1;
  localparam int unsigned EpochW  = 3;
  localparam int unsigned EntW    = 1 + EpochW + 2 * acc_pkg::POS_W;
  localparam int unsigned MinMsb  = 2 * acc_pkg::POS_W - 1;

  acc_pkg::state_e   state_q, state_d;
  acc_pkg::verdict_e verdict_q, verdict_d;

  logic [CntW-1:0]   idx_q, idx_d;
  acc_pkg::pos_t     first_q, first_d, last_q, last_d;
  acc_pkg::pos_t     ls_q, ls_d, lt_q, lt_d;
  acc_pkg::pos_t     lo_q, lo_d, hi_q, hi_d;
  logic              any_q, any_d;
  logic              pend_q, pend_d;
  logic [EpochW-1:0] epoch_q, epoch_d;
  logic              boot_q, boot_d;

  logic              out_valid_q;
  acc_pkg::verdict_e out_verdict_q;
  logic              out_links_q;
  acc_pkg::pos_t     out_lo_q, out_hi_q;
  logic              out_load;

  logic              in_fire;
  logic              link_ok;
  logic              idx_in_range;
  logic              src_issue, tgt_issue;
  logic              src_hit, tgt_hit, src_fold;
  logic              last_wipe;
  logic              violation;

  logic              src_re, src_we, tgt_re, tgt_we;
  logic [AddrW-1:0]  src_rd_addr, tgt_rd_addr, src_wr_addr, tgt_wr_addr;
  logic [EntW-1:0]   src_wr_data, tgt_wr_data, src_rd_data, tgt_rd_data;

  acc_pkg::mm_req_t  mm_req;
  acc_pkg::mm_rsp_t  mm_rsp;

  // Per-position partner bounds: {linked, epoch, min, max}
  acc_ram #(.WIDTH(EntW), .DEPTH(Depth)) u_src_ram (
    .clk_i     (clk_i),
    .we_i      (src_we),
    .wr_addr_i (src_wr_addr),
    .wr_data_i (src_wr_data),
    .re_i      (src_re),
    .rd_addr_i (src_rd_addr),
    .rd_data_o (src_rd_data)
  );

  acc_ram #(.WIDTH(EntW), .DEPTH(Depth)) u_tgt_ram (
    .clk_i     (clk_i),
    .we_i      (tgt_we),
    .wr_addr_i (tgt_wr_addr),
    .wr_data_i (tgt_wr_data),
    .re_i      (tgt_re),
    .rd_addr_i (tgt_rd_addr),
    .rd_data_o (tgt_rd_data)
  );

  acc_minmax_unit u_mm (
    .req_i (mm_req),
    .rsp_o (mm_rsp)
  );

  // Handshake and walk conditions
  assign in_fire      = in_i.valid && in_i.ready;
  assign link_ok      = (32'(in_i.link_source) < 32'(MAX_WORDS)) &&
                        (32'(in_i.link_target) < 32'(MAX_WORDS));
  assign idx_in_range = 32'(idx_q) < 32'(MAX_WORDS);
  assign src_issue    = idx_q <= {1'b0, last_q};
  assign tgt_issue    = idx_q <= {1'b0, hi_q};
  assign last_wipe    = idx_q == CntW'(Depth - 1);

  // An entry is linked when its bit is set and it carries the current epoch
  assign src_hit   = src_rd_data[EntW-1] && (src_rd_data[EntW-2 -: EpochW] == epoch_q);
  assign tgt_hit   = tgt_rd_data[EntW-1] && (tgt_rd_data[EntW-2 -: EpochW] == epoch_q);
  assign src_fold  = pend_q && src_hit;
  assign violation = (state_q == acc_pkg::ST_TGT_WALK) && pend_q && tgt_hit &&
                     mm_rsp.outside;

  // Steer the shared compare unit
  always_comb begin
    mm_req = '0;
    unique case (state_q)
      acc_pkg::ST_LINK_SRC: begin
        mm_req.init    = !src_hit;
        mm_req.acc_lo  = src_rd_data[MinMsb:acc_pkg::POS_W];
        mm_req.acc_hi  = src_rd_data[acc_pkg::POS_W-1:0];
        mm_req.cand_lo = lt_q;
        mm_req.cand_hi = lt_q;
      end
      acc_pkg::ST_LINK_TGT: begin
        mm_req.init    = !tgt_hit;
        mm_req.acc_lo  = tgt_rd_data[MinMsb:acc_pkg::POS_W];
        mm_req.acc_hi  = tgt_rd_data[acc_pkg::POS_W-1:0];
        mm_req.cand_lo = ls_q;
        mm_req.cand_hi = ls_q;
      end
      acc_pkg::ST_SRC_WALK: begin
        mm_req.init    = !any_q;
        mm_req.acc_lo  = lo_q;
        mm_req.acc_hi  = hi_q;
        mm_req.cand_lo = src_rd_data[MinMsb:acc_pkg::POS_W];
        mm_req.cand_hi = src_rd_data[acc_pkg::POS_W-1:0];
      end
      acc_pkg::ST_TGT_WALK: begin
        mm_req.init    = 1'b0;
        mm_req.acc_lo  = first_q;
        mm_req.acc_hi  = last_q;
        mm_req.cand_lo = tgt_rd_data[MinMsb:acc_pkg::POS_W];
        mm_req.cand_hi = tgt_rd_data[acc_pkg::POS_W-1:0];
      end
      default: begin
        mm_req = '0;
      end
    endcase
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      acc_pkg::ST_IDLE: begin
        if (in_fire) begin
          case (acc_pkg::mode_e'(in_i.mode))
            acc_pkg::MODE_CLEAR: state_d = (epoch_q == '1) ? acc_pkg::ST_WIPE :
                                                             acc_pkg::ST_DONE;
            acc_pkg::MODE_LINK:  state_d = link_ok ? acc_pkg::ST_LINK_RD : acc_pkg::ST_DONE;
            acc_pkg::MODE_QUERY: state_d = (in_i.span_first == in_i.span_last) ?
                                           acc_pkg::ST_DONE : acc_pkg::ST_SRC_WALK;
            default:             state_d = acc_pkg::ST_DONE;
          endcase
        end
      end
      acc_pkg::ST_LINK_RD:  state_d = acc_pkg::ST_LINK_SRC;
      acc_pkg::ST_LINK_SRC: state_d = acc_pkg::ST_LINK_TGT;
      acc_pkg::ST_LINK_TGT: state_d = acc_pkg::ST_DONE;
      acc_pkg::ST_SRC_WALK: begin
        if (!src_issue) begin
          state_d = (any_q || src_fold) ? acc_pkg::ST_TGT_WALK : acc_pkg::ST_DONE;
        end
      end
      acc_pkg::ST_TGT_WALK: begin
        if (!tgt_issue || violation) begin
          state_d = acc_pkg::ST_DONE;
        end
      end
      acc_pkg::ST_DONE: begin
        if (!out_valid_q || out_o.ready) begin
          state_d = acc_pkg::ST_IDLE;
        end
      end
      acc_pkg::ST_WIPE: begin
        if (last_wipe) begin
          state_d = boot_q ? acc_pkg::ST_IDLE : acc_pkg::ST_DONE;
        end
      end
      default: state_d = acc_pkg::ST_IDLE;
    endcase
  end

  // Datapath and memory control
  always_comb begin
    idx_d       = idx_q;
    first_d     = first_q;
    last_d      = last_q;
    ls_d        = ls_q;
    lt_d        = lt_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    any_d       = any_q;
    pend_d      = pend_q;
    verdict_d   = verdict_q;
    epoch_d     = epoch_q;
    boot_d      = boot_q;
    out_load    = 1'b0;
    src_re      = 1'b0;
    tgt_re      = 1'b0;
    src_we      = 1'b0;
    tgt_we      = 1'b0;
    src_rd_addr = idx_q[AddrW-1:0];
    tgt_rd_addr = idx_q[AddrW-1:0];
    src_wr_addr = ls_q[AddrW-1:0];
    tgt_wr_addr = lt_q[AddrW-1:0];
    src_wr_data = {1'b1, epoch_q, mm_rsp.lo, mm_rsp.hi};
    tgt_wr_data = {1'b1, epoch_q, mm_rsp.lo, mm_rsp.hi};

    unique case (state_q)
      acc_pkg::ST_IDLE: begin
        // Latch the word and clear the result fields
        if (in_fire) begin
          ls_d      = in_i.link_source;
          lt_d      = in_i.link_target;
          first_d   = in_i.span_first;
          last_d    = in_i.span_last;
          idx_d     = {1'b0, in_i.span_first};
          lo_d      = '0;
          hi_d      = '0;
          any_d     = 1'b0;
          pend_d    = 1'b0;
          verdict_d = acc_pkg::VERD_ACK;
          case (acc_pkg::mode_e'(in_i.mode))
            acc_pkg::MODE_CLEAR: begin
              // Advance the epoch; a wrap starts a clearing pass from entry zero
              epoch_d = epoch_q + 1'b1;
              idx_d   = '0;
            end
            acc_pkg::MODE_QUERY: verdict_d = (in_i.span_first == in_i.span_last) ?
                                             acc_pkg::VERD_EXCL : acc_pkg::VERD_OK;
            default:             verdict_d = acc_pkg::VERD_ACK;
          endcase
        end
      end
      acc_pkg::ST_LINK_RD: begin
        // Fetch both partner entries
        src_re      = 1'b1;
        tgt_re      = 1'b1;
        src_rd_addr = ls_q[AddrW-1:0];
        tgt_rd_addr = lt_q[AddrW-1:0];
      end
      acc_pkg::ST_LINK_SRC: begin
        src_we = 1'b1;
      end
      acc_pkg::ST_LINK_TGT: begin
        tgt_we = 1'b1;
      end
      acc_pkg::ST_SRC_WALK: begin
        // Fold the entry fetched last cycle into the projection
        if (src_fold) begin
          lo_d  = mm_rsp.lo;
          hi_d  = mm_rsp.hi;
          any_d = 1'b1;
        end
        // Issue the next source position, or hand over to the target walk
        if (src_issue) begin
          src_re = 1'b1;
          pend_d = idx_in_range;
          idx_d  = idx_q + 1'b1;
        end else begin
          pend_d = 1'b0;
          idx_d  = {1'b0, lo_d};
        end
      end
      acc_pkg::ST_TGT_WALK: begin
        // Check the entry fetched last cycle, issue the next one
        if (violation) begin
          verdict_d = acc_pkg::VERD_BAD;
          pend_d    = 1'b0;
        end else if (tgt_issue) begin
          tgt_re = 1'b1;
          pend_d = idx_in_range;
          idx_d  = idx_q + 1'b1;
        end else begin
          pend_d = 1'b0;
        end
      end
      acc_pkg::ST_DONE: begin
        out_load = !out_valid_q || out_o.ready;
      end
      acc_pkg::ST_WIPE: begin
        // Mark one entry of each RAM unlinked per cycle
        src_we      = 1'b1;
        tgt_we      = 1'b1;
        src_wr_addr = idx_q[AddrW-1:0];
        tgt_wr_addr = idx_q[AddrW-1:0];
        src_wr_data = '0;
        tgt_wr_data = '0;
        idx_d       = idx_q + 1'b1;
        if (last_wipe) begin
          boot_d = 1'b0;
        end
      end
      default: begin
        pend_d = 1'b0;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= acc_pkg::ST_WIPE;
      idx_q       <= '0;
      epoch_q     <= '0;
      boot_q      <= 1'b1;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      epoch_q <= epoch_d;
      boot_q  <= boot_d;
      pend_q  <= pend_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    first_q   <= first_d;
    last_q    <= last_d;
    ls_q      <= ls_d;
    lt_q      <= lt_d;
    lo_q      <= lo_d;
    hi_q      <= hi_d;
    any_q     <= any_d;
    verdict_q <= verdict_d;
    if (out_load) begin
      out_verdict_q <= verdict_q;
      out_links_q   <= any_q;
      out_lo_q      <= lo_q;
      out_hi_q      <= hi_q;
    end
  end

  // Ports
  assign in_i.ready           = state_q == acc_pkg::ST_IDLE;
  assign out_o.valid          = out_valid_q;
  assign out_o.verdict        = out_verdict_q;
  assign out_o.has_links      = out_links_q;
  assign out_o.projected_low  = out_lo_q;
  assign out_o.projected_high = out_hi_q;

  // An accepted word always leaves idle
  a_leave_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> state_q != acc_pkg::ST_IDLE)
    else $error("accepted word did not start processing");

  // A fetch is in flight only during a walk
  a_pend_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> (state_q == acc_pkg::ST_SRC_WALK || state_q == acc_pkg::ST_TGT_WALK))
    else $error("pending fetch outside a walk");

  // Without links the projection reads zero
  a_no_links_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_links_q |-> out_lo_q == '0 && out_hi_q == '0)
    else $error("projection nonzero without links");

  // An excluded span carries no projection
  a_excl_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_verdict_q == acc_pkg::VERD_EXCL |-> !out_links_q)
    else $error("one-word span reported links");

  // A projection is an ordered range
  a_proj_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_links_q |-> out_lo_q <= out_hi_q)
    else $error("projected range reversed");

endmodule
